/* rtl/core/clr_pkg.sv */
// shared types, constants and window check for the clipped line rasterizer
`timescale 1ns / 1ps
`default_nettype none
package clr_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 64;
	localparam int COORD_BITS = 12;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// register field widths are fixed
	localparam int SW_W      = 8;
	localparam int SH_W      = 7;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [SW_W-1:0] SW_RESET = SW_W'(80);
	localparam logic [SH_W-1:0] SH_RESET = SH_W'(24);

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// line deltas and the error term
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int ERR_W  = COORD_BITS + 4;

	// compare width wide enough for coordinates, registers and limits
	localparam int CMP_W = ((COORD_BITS > 11) ? COORD_BITS : 11) + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [MAX_WIDTH-1:0] row_data_t;
	typedef logic signed [ERR_W-1:0] err_t;

	// current pixel of the line walk
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} pix_t;

	function automatic logic in_win(coord_t x, coord_t y, logic [SW_W-1:0] w,
			logic [SH_W-1:0] h);
		logic [CMP_W-1:0] xu;
		logic [CMP_W-1:0] yu;
		xu = CMP_W'(unsigned'(x));
		yu = CMP_W'(unsigned'(y));
		return !x[COORD_BITS-1] && !y[COORD_BITS-1]
			&& (xu < CMP_W'(MAX_WIDTH)) && (xu < CMP_W'(w))
			&& (yu < CMP_W'(MAX_HEIGHT)) && (yu < CMP_W'(h));
	endfunction

endpackage
`default_nettype wire

/* rtl/core/clr_row_mem.sv */
// framebuffer row memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module clr_row_mem import clr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      rd_en,
	input  wire row_t      rd_addr,
	output row_data_t      rd_data,
	input  wire logic      wr_en,
	input  wire row_t      wr_addr,
	input  wire row_data_t wr_data
);

	row_data_t mem [MAX_HEIGHT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read returns the contents before a write at the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/clr_walker.sv */
// bresenham error-term stepper, one pixel per advance
`timescale 1ns / 1ps
`default_nettype none
module clr_walker import clr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   load,
	input  wire coord_t x0,
	input  wire coord_t y0,
	input  wire coord_t x1,
	input  wire coord_t y1,
	input  wire logic   advance,
	output pix_t        pix
);

	coord_t x_q, y_q, x1_q, y1_q;
	err_t   dx_q, dy_q, err_q;
	logic   sx_neg_q, sy_neg_q;

	logic signed [DIFF_W-1:0] ddx, ddy, adx, ady;
	err_t   dx_ld, dy_ld;
	err_t   e2, err_n;
	logic   step_x, step_y;
	coord_t x_n, y_n;

	always_comb begin
		ddx   = DIFF_W'(x1) - DIFF_W'(x0);
		ddy   = DIFF_W'(y1) - DIFF_W'(y0);
		adx   = ddx[DIFF_W-1] ? -ddx : ddx;
		ady   = ddy[DIFF_W-1] ? -ddy : ddy;
		dx_ld = ERR_W'(adx);
		dy_ld = -ERR_W'(ady);
	end

	always_comb begin
		e2     = err_q <<< 1;
		step_x = (e2 >= dy_q);
		step_y = (e2 <= dx_q);
		err_n  = err_q + (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
		x_n    = x_q;
		y_n    = y_q;
		if (step_x) begin
			x_n = sx_neg_q ? (x_q - coord_t'(1)) : (x_q + coord_t'(1));
		end
		if (step_y) begin
			y_n = sy_neg_q ? (y_q - coord_t'(1)) : (y_q + coord_t'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q      <= x0;
			y_q      <= y0;
			x1_q     <= x1;
			y1_q     <= y1;
			dx_q     <= dx_ld;
			dy_q     <= dy_ld;
			err_q    <= dx_ld + dy_ld;
			sx_neg_q <= !(x0 < x1);
			sy_neg_q <= !(y0 < y1);
		end else if (advance) begin
			x_q   <= x_n;
			y_q   <= y_n;
			err_q <= err_n;
		end
	end

	assign pix.x    = x_q;
	assign pix.y    = y_q;
	assign pix.last = (x_q == x1_q) && (y_q == y1_q);

endmodule
`default_nettype wire

/* rtl/core/clipped_line_rasterizer.sv */
// top level: operation sequencer, pixel read-modify-write and result register
//
//  channel  direction  handshake          payload
//  in       to block   in_valid/in_stall  op, start_x, start_y, end_x, end_y
//  out      from block out_valid/out_stall pixel_value
//  cfg      to block   cfg_valid/cfg_ready cfg_index, cfg_data
//
// clear ends in S_DONE, read runs S_RDATA; draw walks N = max(|dx|, |dy|) + 1 pixels
// in S_WALK, one pixel a cycle through the row memory read-modify-write port.
// after reset the framebuffer reads blank at once: per-row valid bits, no sweep.
// a new item is taken once the previous one has its result in the output register;
// a stalled result only holds back the end of the next item.
`timescale 1ns / 1ps
`default_nettype none
module clipped_line_rasterizer import clr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           op,
	input  wire coord_t               start_x,
	input  wire coord_t               start_y,
	input  wire coord_t               end_x,
	input  wire coord_t               end_y,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      pixel_value,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_WALK  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_RDATA = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [SW_W-1:0]   width_q;
	logic [SH_W-1:0]   height_q;
	logic [MAX_HEIGHT-1:0] row_valid_q;

	logic      pv_s1;
	col_t      px_s1;
	row_t      py_s1;
	logic      rd_hit_q;
	logic      wv_q;
	row_t      wa_q;
	row_data_t wdata_q;
	logic      res_q;
	logic      out_valid_q;
	logic      pixel_q;

	logic      in_accept, out_free, walk_hit, rd_hit_in, fwd;
	pix_t      pix;
	logic      mem_rd_en;
	row_t      mem_rd_addr;
	row_data_t mem_rd_data, base_row, new_row;

	assign in_stall    = (state_q != S_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;
	assign out_free    = !out_valid_q || !out_stall;

	assign walk_hit = in_win(pix.x, pix.y, width_q, height_q);
	assign rd_hit_in = in_win(start_x, start_y, width_q, height_q);

	assign mem_rd_en   = (state_q == S_WALK) || (in_accept && (op == OP_READ));
	assign mem_rd_addr = (state_q == S_WALK) ? pix.y[ROW_W-1:0] : start_y[ROW_W-1:0];

	// the write of the previous pixel lands at the same edge as this pixel's read
	always_comb begin
		fwd      = wv_q && (wa_q == py_s1);
		base_row = fwd ? wdata_q : (row_valid_q[py_s1] ? mem_rd_data : '0);
		new_row  = base_row | (row_data_t'(1) << px_s1);
	end

	clr_walker u_walker (
		.clk     (clk),
		.load    (in_accept && (op == OP_DRAW)),
		.x0      (start_x),
		.y0      (start_y),
		.x1      (end_x),
		.y1      (end_y),
		.advance (state_q == S_WALK),
		.pix     (pix)
	);

	clr_row_mem u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (pv_s1),
		.wr_addr (py_s1),
		.wr_data (new_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= SW_RESET;
			height_q    <= SH_RESET;
			row_valid_q <= '0;
			pv_s1       <= 1'b0;
			wv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data[SH_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			pv_s1 <= (state_q == S_WALK) && walk_hit;
			wv_q  <= pv_s1;
			if (pv_s1) begin
				row_valid_q[py_s1] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						unique case (op)
							OP_CLEAR: begin
								row_valid_q <= '0;
								state_q     <= S_DONE;
							end
							OP_DRAW: state_q <= S_WALK;
							OP_READ: state_q <= S_RDATA;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WALK: begin
					if (pix.last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_DONE;
				S_RDATA: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WALK) begin
			px_s1 <= pix.x[COL_W-1:0];
			py_s1 <= pix.y[ROW_W-1:0];
		end else if (in_accept) begin
			px_s1    <= start_x[COL_W-1:0];
			py_s1    <= start_y[ROW_W-1:0];
			rd_hit_q <= rd_hit_in;
		end
		wa_q    <= py_s1;
		wdata_q <= new_row;
		if (in_accept) begin
			res_q <= 1'b0;
		end else if (state_q == S_RDATA) begin
			res_q <= rd_hit_q && row_valid_q[py_s1] && mem_rd_data[px_s1];
		end
		if ((state_q == S_DONE) && out_free) begin
			pixel_q <= res_q;
		end
	end

	a_wr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> (state_q == S_WALK || state_q == S_DRAIN))
		else $error("pixel write outside a line walk");

	a_read_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDATA) |-> (!pv_s1 && !wv_q))
		else $error("pixel read overlaps a pending write");

	a_clear_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && op == OP_CLEAR) |=> (row_valid_q == '0))
		else $error("clear left a row marked valid");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the done state");

endmodule
`default_nettype wire
